>>> src/gsc_pkg.sv
// Shared types, constants and helpers for the gas sensor calibration block.
// Used by gsc_divider, gsc_seq and gas_sensor_calibration_fsm; no dependencies.
package gsc_pkg;

  localparam int ADC_BITS   = 10;
  localparam int TIMER_BITS = 20;

  localparam logic [ADC_BITS-1:0]   ADC_MAX   = '1;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [31:0]           ALL32     = 32'hFFFF_FFFF;

  localparam int RES_W   = 16;               // load resistor width
  localparam int ACC_W   = 40;               // accumulator width
  localparam int NUM_RS_W = RES_W + ADC_BITS; // width of RL*(ADC_MAX-adc)

  // bit-serial divider geometry: dividends are left aligned in DIV_NUM_W bits
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_ADDR_W-1:0] CFG_DISCONNECT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOAD_RES   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PREHEAT    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_COUNT      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAF        = 3'd5;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [1:0] {
    ST_NOTCONN = 2'd0,
    ST_PREHEAT = 2'd1,
    ST_CALIB   = 2'd2,
    ST_READY   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV_RS,
    S_ACC,
    S_DIV_AVG,
    S_DIV_RO,
    S_DIV_RATIO,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] disconnect_level;
    logic [RES_W-1:0]    load_resistance;
    logic [19:0]         preheat_ms;
    logic [15:0]         sample_interval_ms;
    logic [7:0]          sample_count;
    logic [15:0]         clean_air_factor;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        sample_done;
    logic        ratio_valid;
    logic [31:0] ratio_q16;
    logic [31:0] ro_ohms;
    logic [31:0] rs_ohms;
    logic [1:0]  status;
  } res_t;

  function automatic logic [31:0] sat32(input logic [DIV_NUM_W-1:0] q);
    return (|q[DIV_NUM_W-1:32]) ? ALL32 : q[31:0];
  endfunction

endpackage

>>> src/gsc_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on gsc_pkg. A zero divisor yields a one in every quotient bit it computes.
module gsc_divider import gsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;

  logic [DIV_DEN_W:0] trial;
  logic [DIV_DEN_W:0] diff;
  logic               ge;

  assign trial = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.nbits;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
      num_nxt  = req.dividend;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      num_nxt = {num_r[DIV_NUM_W-2:0], 1'b0};
      quo_nxt = {quo_r[DIV_NUM_W-2:0], ge};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> src/gsc_seq.sv
// Per-tick sequencer: sensor mode, timers, averaging and the divisions
// it hands to the shared bit-serial divider. Depends on gsc_pkg.
module gsc_seq import gsc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  input  logic [ADC_BITS-1:0] in_adc,
  output logic                in_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res,
  output div_req_t            div_req,
  input  div_rsp_t            div_rsp
);

  seq_state_t state_r, state_nxt;
  mode_t      mode_r, mode_nxt;

  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [ADC_BITS-1:0]   prev_r, prev_nxt;
  logic [ADC_BITS-1:0]   adc_r, adc_nxt;
  logic [ACC_W-1:0]      accum_r, accum_nxt;
  logic [7:0]            taken_r, taken_nxt;
  logic [31:0]           ro_r, ro_nxt;
  logic [31:0]           rs_r, rs_nxt;
  logic                  rs_seen_r, rs_seen_nxt;
  logic [31:0]           ratio_r, ratio_nxt;
  logic                  done_r, done_nxt;
  logic [31:0]           rs_smp_r, rs_smp_nxt;

  // shared per-tick terms
  logic [TIMER_BITS-1:0] el_inc;
  logic [ADC_BITS-1:0]   adc_diff;
  logic                  disconnected;
  logic                  interval_hit;
  logic                  preheat_hit;
  logic [NUM_RS_W-1:0]   rs_num;
  logic [ACC_W-1:0]      acc_sum;
  logic [7:0]            taken_inc;
  logic [7:0]            n_eff;
  logic [31:0]           q_sat;

  assign el_inc       = (elapsed_r == TIMER_MAX) ? elapsed_r : elapsed_r + TIMER_BITS'(1);
  assign adc_diff     = (adc_r > prev_r) ? adc_r - prev_r : prev_r - adc_r;
  assign disconnected = adc_r >= cfg.disconnect_level;
  assign interval_hit = 32'(el_inc) >= 32'(cfg.sample_interval_ms);
  assign preheat_hit  = 32'(el_inc) >= 32'(cfg.preheat_ms);
  assign rs_num       = NUM_RS_W'(cfg.load_resistance) * NUM_RS_W'(ADC_MAX - adc_r);
  assign acc_sum      = accum_r + ACC_W'(rs_smp_r);
  assign taken_inc    = taken_r + 8'd1;
  assign n_eff        = (cfg.sample_count == 8'd0) ? 8'd1 : cfg.sample_count;
  assign q_sat        = sat32(div_rsp.quotient);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: begin
        if (disconnected || mode_r == ST_NOTCONN || mode_r == ST_PREHEAT || !interval_hit) begin
          state_nxt = S_OUT;
        end else if (adc_r == '0) begin
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_DIV_RS;
        end
      end
      S_DIV_RS: if (div_rsp.done) state_nxt = S_ACC;
      S_ACC: state_nxt = (taken_inc >= n_eff) ? S_DIV_AVG : S_OUT;
      S_DIV_AVG: begin
        if (div_rsp.done) state_nxt = (mode_r == ST_CALIB) ? S_DIV_RO : S_DIV_RATIO;
      end
      S_DIV_RO: if (div_rsp.done) state_nxt = S_DIV_RATIO;
      S_DIV_RATIO: if (div_rsp.done) state_nxt = S_OUT;
      S_OUT: if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      S_IDLE:  in_ready  = 1'b1;
      S_OUT:   res_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
      end
    endcase
  end

  // datapath and divider requests
  always_comb begin
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    prev_nxt    = prev_r;
    adc_nxt     = adc_r;
    accum_nxt   = accum_r;
    taken_nxt   = taken_r;
    ro_nxt      = ro_r;
    rs_nxt      = rs_r;
    rs_seen_nxt = rs_seen_r;
    ratio_nxt   = ratio_r;
    done_nxt    = done_r;
    rs_smp_nxt  = rs_smp_r;
    div_req     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          adc_nxt  = in_adc;
          done_nxt = 1'b0;
        end
      end
      S_EVAL: begin
        elapsed_nxt = el_inc;
        if (disconnected) begin
          mode_nxt = ST_NOTCONN;
        end else if (mode_r == ST_NOTCONN) begin
          mode_nxt    = ST_PREHEAT;
          elapsed_nxt = '0;
          prev_nxt    = adc_r;
        end else if (mode_r == ST_PREHEAT) begin
          if (adc_diff > ADC_BITS'(1)) begin
            elapsed_nxt = '0;
            prev_nxt    = adc_r;
          end else if (preheat_hit) begin
            mode_nxt    = ST_CALIB;
            elapsed_nxt = '0;
            accum_nxt   = '0;
            taken_nxt   = '0;
          end
        end else if (interval_hit) begin
          elapsed_nxt = '0;
          if (adc_r == '0) begin
            rs_smp_nxt = ALL32;
          end else begin
            // Rs = RL*(ADC_MAX-adc)/adc, numerator left aligned
            div_req.start    = 1'b1;
            div_req.dividend = DIV_NUM_W'(rs_num) << (DIV_NUM_W - NUM_RS_W);
            div_req.divisor  = DIV_DEN_W'(adc_r);
            div_req.nbits    = DIV_CNT_W'(NUM_RS_W);
          end
        end
      end
      S_DIV_RS: if (div_rsp.done) rs_smp_nxt = q_sat;
      S_ACC: begin
        accum_nxt = acc_sum;
        taken_nxt = taken_inc;
        if (taken_inc >= n_eff) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NUM_W'(acc_sum) << (DIV_NUM_W - ACC_W);
          div_req.divisor  = DIV_DEN_W'(n_eff);
          div_req.nbits    = DIV_CNT_W'(ACC_W);
        end
      end
      S_DIV_AVG: begin
        if (div_rsp.done) begin
          accum_nxt   = '0;
          taken_nxt   = '0;
          elapsed_nxt = '0;
          done_nxt    = 1'b1;
          div_req.start = 1'b1;
          if (mode_r == ST_CALIB) begin
            // Ro = avg*256/factor; zero factor saturates via all-ones quotient
            div_req.dividend = DIV_NUM_W'(q_sat) << (DIV_NUM_W - 32 - 8 + 8);
            div_req.divisor  = DIV_DEN_W'(cfg.clean_air_factor);
            div_req.nbits    = DIV_CNT_W'(ACC_W);
          end else begin
            rs_nxt      = q_sat;
            rs_seen_nxt = 1'b1;
            div_req.dividend = DIV_NUM_W'(q_sat) << 16;
            div_req.divisor  = ro_r;
            div_req.nbits    = DIV_CNT_W'(DIV_NUM_W);
          end
        end
      end
      S_DIV_RO: begin
        if (div_rsp.done) begin
          ro_nxt   = q_sat;
          mode_nxt = ST_READY;
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NUM_W'(rs_r) << 16;
          div_req.divisor  = q_sat;
          div_req.nbits    = DIV_CNT_W'(DIV_NUM_W);
        end
      end
      S_DIV_RATIO: if (div_rsp.done) ratio_nxt = q_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mode_r    <= ST_NOTCONN;
      elapsed_r <= '0;
      prev_r    <= '0;
      accum_r   <= '0;
      taken_r   <= '0;
      ro_r      <= '0;
      rs_r      <= '0;
      rs_seen_r <= 1'b0;
      ratio_r   <= '0;
      done_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      prev_r    <= prev_nxt;
      accum_r   <= accum_nxt;
      taken_r   <= taken_nxt;
      ro_r      <= ro_nxt;
      rs_r      <= rs_nxt;
      rs_seen_r <= rs_seen_nxt;
      ratio_r   <= ratio_nxt;
      done_r    <= done_nxt;
    end
    adc_r    <= adc_nxt;
    rs_smp_r <= rs_smp_nxt;
  end

  always_comb begin
    res.status      = mode_r;
    res.rs_ohms     = rs_r;
    res.ro_ohms     = ro_r;
    res.ratio_valid = (mode_r == ST_READY) && rs_seen_r;
    res.ratio_q16   = res.ratio_valid ? ratio_r : 32'd0;
    res.sample_done = done_r;
  end

endmodule

>>> src/gas_sensor_calibration_fsm.sv
// Top level: configuration registers, tick sequencer, shared divider and
// the output register. Depends on gsc_pkg, gsc_divider and gsc_seq.
//
//  channel  signals                      moves
//  in_      in_tvalid/in_tready/in_tdata  one ADC tick per transfer
//  out_     out_tvalid/out_tready/out_tdata  one result per tick
//  cfg_     cfg_valid/cfg_ready/cfg_addr/cfg_data  register write, always ready
//
// A tick with no resistance sample goes through idle, evaluate and output.
// A sample tick runs the bit-serial divider for Rs (26 steps) unless the
// reading is zero, and on the last sample of an average also the mean (40),
// Ro (40, calibration only) and Rs/Ro (48).
// Reset is synchronous, active low, and needs no clearing pass. The output
// register holds a result until taken; the next tick is accepted meanwhile
// and its result waits in the sequencer if the register is still full.
module gas_sensor_calibration_fsm import gsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] adc_sample, rest zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] status, [33:2] rs_ohms, [65:34] ro_ohms, [97:66] ratio_q16,
  // [98] ratio_valid, [99] sample_done, [103:100] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  div_req_t div_req;
  div_rsp_t div_rsp;
  res_t     res;
  logic     res_valid;
  logic     res_ready;
  logic     out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_addr)
        CFG_DISCONNECT: cfg_nxt.disconnect_level   = cfg_data[ADC_BITS-1:0];
        CFG_LOAD_RES:   cfg_nxt.load_resistance    = cfg_data[RES_W-1:0];
        CFG_PREHEAT:    cfg_nxt.preheat_ms         = cfg_data[19:0];
        CFG_INTERVAL:   cfg_nxt.sample_interval_ms = cfg_data[15:0];
        CFG_COUNT:      cfg_nxt.sample_count       = cfg_data[7:0];
        CFG_CAF:        cfg_nxt.clean_air_factor   = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  gsc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_adc    (in_tdata[ADC_BITS-1:0]),
    .in_ready  (in_tready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  gsc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_DATA_W'(res);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.disconnect_level   <= ADC_BITS'(1000);
      cfg_r.load_resistance    <= 16'd5000;
      cfg_r.preheat_ms         <= 20'd20000;
      cfg_r.sample_interval_ms <= 16'd50;
      cfg_r.sample_count       <= 8'd5;
      cfg_r.clean_air_factor   <= 16'd2516;
      out_valid_r              <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> verif/gas_sensor_calibration_fsm_test.sv
`timescale 1ns / 1ps
// Self-checking bench for gas_sensor_calibration_fsm: ADC ticks in, status and Rs/Ro out.
// A class tracks the calibration sequence and holds the results still owed; needs gsc_pkg.
import gsc_pkg::*;

class calib_tracker;
  logic [ADC_BITS-1:0]   disc_level;
  logic [RES_W-1:0]      load_res;
  logic [19:0]           preheat_len;
  logic [15:0]           interval_len;
  logic [7:0]            avg_len;
  logic [15:0]           caf;

  mode_t                 mode;
  logic [TIMER_BITS-1:0] elapsed;
  logic [ADC_BITS-1:0]   settle_ref;
  logic [ACC_W-1:0]      rs_sum;
  logic [7:0]            rs_taken;
  logic [31:0]           ro_ohms;
  logic [31:0]           rs_ohms;
  bit                    rs_seen;

  res_t                  expected_results[$];
  int                    errors;

  function new();
    disc_level   = 10'd1000;
    load_res     = 16'd5000;
    preheat_len  = 20'd20000;
    interval_len = 16'd50;
    avg_len      = 8'd5;
    caf          = 16'd2516;
    mode         = ST_NOTCONN;
    elapsed      = '0;
    settle_ref   = '0;
    rs_sum       = '0;
    rs_taken     = '0;
    ro_ohms      = '0;
    rs_ohms      = '0;
    rs_seen      = 1'b0;
    errors       = 0;
  endfunction

  function void set_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_DISCONNECT: disc_level   = val[ADC_BITS-1:0];
      CFG_LOAD_RES:   load_res     = val[RES_W-1:0];
      CFG_PREHEAT:    preheat_len  = val[19:0];
      CFG_INTERVAL:   interval_len = val[15:0];
      CFG_COUNT:      avg_len      = val[7:0];
      CFG_CAF:        caf          = val[15:0];
      default: ;
    endcase
  endfunction

  // Rs = RL * (full scale - adc) / adc; a zero reading pins it at all ones
  function logic [31:0] ohms_at(input logic [ADC_BITS-1:0] adc);
    if (adc == 0) return ALL32;
    return 32'((64'(load_res) * 64'(ADC_MAX - adc)) / 64'(adc));
  endfunction

  function void note_tick(input logic [ADC_BITS-1:0] adc);
    logic [ADC_BITS-1:0] diff;
    logic [7:0]          n;
    logic [63:0]         avg;
    logic [63:0]         q;
    res_t                want;
    bit                  done;
    done = 1'b0;
    if (elapsed != TIMER_MAX) elapsed++;

    if (adc >= disc_level) begin
      mode = ST_NOTCONN;
    end else if (mode == ST_NOTCONN) begin
      mode       = ST_PREHEAT;
      elapsed    = '0;
      settle_ref = adc;
    end else if (mode == ST_PREHEAT) begin
      diff = (adc > settle_ref) ? adc - settle_ref : settle_ref - adc;
      if (diff > 1) begin
        elapsed    = '0;
        settle_ref = adc;
      end else if (elapsed >= preheat_len) begin
        mode     = ST_CALIB;
        rs_sum   = '0;
        rs_taken = '0;
        elapsed  = '0;
      end
    end else if (elapsed >= interval_len) begin
      n        = (avg_len == 0) ? 8'd1 : avg_len;
      elapsed  = '0;
      rs_sum   = rs_sum + ACC_W'(ohms_at(adc));
      rs_taken = rs_taken + 8'd1;
      if (rs_taken >= n) begin
        avg = 64'(rs_sum) / 64'(n);
        if (avg > 64'(ALL32)) avg = 64'(ALL32);
        rs_sum   = '0;
        rs_taken = '0;
        done     = 1'b1;
        if (mode == ST_CALIB) begin
          if (caf == 0) begin
            ro_ohms = ALL32;
          end else begin
            q       = (avg << 8) / 64'(caf);
            ro_ohms = (q > 64'(ALL32)) ? ALL32 : q[31:0];
          end
          mode = ST_READY;
        end else begin
          rs_ohms = avg[31:0];
          rs_seen = 1'b1;
        end
      end
    end

    want.status      = mode;
    want.rs_ohms     = rs_ohms;
    want.ro_ohms     = ro_ohms;
    want.ratio_valid = (mode == ST_READY) && rs_seen;
    want.sample_done = done;
    want.ratio_q16   = '0;
    if (want.ratio_valid) begin
      if (ro_ohms == 0) begin
        want.ratio_q16 = ALL32;
      end else begin
        q              = (64'(rs_ohms) << 16) / 64'(ro_ohms);
        want.ratio_q16 = (q > 64'(ALL32)) ? ALL32 : q[31:0];
      end
    end
    expected_results.push_back(want);
  endfunction

  function int field_diff(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want === got) return 0;
    $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
    return 1;
  endfunction

  function void check_result(input logic [OUT_DATA_W-1:0] word);
    res_t got;
    res_t want;
    got = res_t'(word[$bits(res_t)-1:0]);
    if (expected_results.size() == 0) begin
      $display("%0t result with nothing pending: actual %0h", $time, word);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    errors += field_diff("status", want.status, got.status);
    errors += field_diff("rs_ohms", want.rs_ohms, got.rs_ohms);
    errors += field_diff("ro_ohms", want.ro_ohms, got.ro_ohms);
    errors += field_diff("ratio_q16", want.ratio_q16, got.ratio_q16);
    errors += field_diff("ratio_valid", want.ratio_valid, got.ratio_valid);
    errors += field_diff("sample_done", want.sample_done, got.sample_done);
    errors += field_diff("pad", '0, 32'(word[OUT_DATA_W-1:$bits(res_t)]));
  endfunction
endclass

module gas_sensor_calibration_fsm_test;
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [9:0] adc_sample, rest zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [1:0] status, [33:2] rs_ohms, [65:34] ro_ohms, [97:66] ratio_q16,
  // [98] ratio_valid, [99] sample_done, [103:100] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  calib_tracker          tracker;
  logic [ADC_BITS-1:0]   walk_base = '0;
  int                    ticks_sent = 0;
  int                    send_idle_pct = 27;
  int                    recv_idle_pct = 62;

  gas_sensor_calibration_fsm i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic wait_drained();
    while (tracker.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_tick(input logic [ADC_BITS-1:0] adc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(adc);
    do @(posedge clk); while (!in_tready);
    tracker.note_tick(adc);
    ticks_sent++;
    // receiver-heavy gaps first, then sender-heavy, then none
    if (ticks_sent < 330) begin
      send_idle_pct = 27;
      recv_idle_pct = 62;
    end else if (ticks_sent < 660) begin
      send_idle_pct = 62;
      recv_idle_pct = 27;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
  endtask

  // registers change only with no tick in flight
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] disc, load, pre, intv, cnt, caf);
    in_tvalid <= 1'b0;
    wait_drained();
    write_reg(CFG_DISCONNECT, disc);
    write_reg(CFG_LOAD_RES, load);
    write_reg(CFG_PREHEAT, pre);
    write_reg(CFG_INTERVAL, intv);
    write_reg(CFG_COUNT, cnt);
    write_reg(CFG_CAF, caf);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ADC_BITS-1:0] new_base(input logic [ADC_BITS-1:0] level);
    if (level < 2) return ADC_BITS'($urandom_range(0, ADC_MAX));
    case ($urandom_range(0, 7))
      0: return '0;
      1: return level - 2;
      default: return ADC_BITS'($urandom_range(0, level - 2));
    endcase
  endfunction

  // mostly a reading that holds within one count, so preheat can settle
  function automatic logic [ADC_BITS-1:0] next_reading(input logic [ADC_BITS-1:0] level,
                                                       input bit noisy);
    int r;
    r = $urandom_range(0, 99);
    if (noisy && r < 3) return ADC_BITS'($urandom_range(0, ADC_MAX));
    if (r < (noisy ? 6 : 1)) walk_base = new_base(level);
    if (noisy && r == 6 && walk_base != 0) return walk_base - 1;
    if (walk_base == ADC_MAX) return walk_base;
    return walk_base + ADC_BITS'($urandom_range(0, 1));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick16();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 1;
      2: return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  task automatic run_phase(input int n_items, input bit noisy,
                           input logic [CFG_DATA_W-1:0] disc, load, pre, intv, cnt, caf);
    reconfigure(disc, load, pre, intv, cnt, caf);
    walk_base = new_base(disc[ADC_BITS-1:0]);
    repeat (n_items) send_tick(next_reading(disc[ADC_BITS-1:0], noisy));
  endtask

  // result side: random back-pressure plus one long hold so the block backs up
  initial begin
    int  hold_left;
    int  results_taken;
    bit  held;
    hold_left     = 0;
    results_taken = 0;
    held          = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        tracker.check_result(out_tdata);
        results_taken++;
      end
      if (!held && results_taken == 150) begin
        held      = 1'b1;
        hold_left = 1000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    // default registers first, then zero reading / zero factor / zero Ro cases
    int directed [22] = '{999, 1000, 1023, 0, 0, 1, 3, 1023, 500,
                          0, 0, 0, 0, 1022, 1, 1023,
                          1022, 1022, 1022, 1022, 1, 512};
    int                    i;
    int                    k;
    int                    n_items;
    bit                    noisy;
    logic [CFG_DATA_W-1:0] disc, load, pre, intv, cnt, caf;
    tracker = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < 22; i++) begin
      if (i == 9) reconfigure(1023, 1, 0, 0, 0, 0);
      else if (i == 16) reconfigure(1023, 16'hFFFF, 0, 0, 1, 16'hFFFF);
      send_tick(directed[i]);
    end

    for (k = 0; k < 14; k++) begin
      disc    = ($urandom_range(0, 2) == 0) ? 1023 : $urandom_range(700, 1023);
      load    = pick16();
      caf     = pick16();
      pre     = $urandom_range(0, 12);
      intv    = $urandom_range(0, 4);
      cnt     = $urandom_range(0, 6);
      n_items = 60;
      noisy   = 1'b1;
      case (k)
        3: begin
          pre     = 20'hFFFFF;   // preheat never completes
          n_items = 25;
        end
        5: begin
          intv    = 16'hFFFF;
          n_items = 25;
        end
        7: begin
          // longest average, one sample per tick, clean readings throughout
          disc    = 1023;
          pre     = 0;
          intv    = 0;
          cnt     = 255;
          n_items = 290;
          noisy   = 1'b0;
        end
        9: begin
          disc    = 0;           // every reading counts as disconnected
          n_items = 20;
        end
        default: ;
      endcase
      run_phase(n_items, noisy, disc, load, pre, intv, cnt, caf);
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);
    if (tracker.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

>>> gas_sensor_calibration_fsm.f
src/gsc_pkg.sv
src/gsc_divider.sv
src/gsc_seq.sv
src/gas_sensor_calibration_fsm.sv
verif/gas_sensor_calibration_fsm_test.sv
